// ===== rtl/ttok_pkg.sv =====
// ---------------------------------------------------------------------------
// ttok_pkg: shared types and helpers for the template tag tokenizer
// Item structs, token kind codes, mode and held-delimiter codes, keyword
// match and character class helpers.
// ---------------------------------------------------------------------------
package ttok_pkg;

  // Input item: one template byte or the end marker
  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } chr_item_t;

  // Result item: one token event
  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       token_done;
    logic       last;
  } tok_item_t;

  // Token kinds
  typedef enum logic [4:0] {
    KIND_TEXT      = 5'd0,
    KIND_VAROPEN   = 5'd1,
    KIND_STMTOPEN  = 5'd2,
    KIND_VARCLOSE  = 5'd3,
    KIND_DOT       = 5'd4,
    KIND_IDENT     = 5'd5,
    KIND_STMTCLOSE = 5'd6,
    KIND_QOPEN     = 5'd7,
    KIND_QCLOSE    = 5'd8,
    KIND_STRLIT    = 5'd9,
    KIND_IF        = 5'd10,
    KIND_FOR       = 5'd11,
    KIND_IN        = 5'd12,
    KIND_ENDIF     = 5'd13,
    KIND_ENDFOR    = 5'd14,
    KIND_ELSE      = 5'd15,
    KIND_ERROR     = 5'd16,
    KIND_EOF       = 5'd17
  } kind_t;

  // Tag modes; the unused code behaves as text
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_VAR  = 2'd1;
  localparam logic [1:0] MODE_STMT = 2'd2;

  // Held delimiter codes
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_LBRACE = 2'd1;
  localparam logic [1:0] HELD_RBRACE = 2'd2;
  localparam logic [1:0] HELD_PCT    = 2'd3;

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // Word buffer geometry
  localparam int          WORD_MAX   = 6;
  localparam logic [2:0]  WCNT_LONG  = 3'd7;

  // Keywords, first byte in the low byte, zero padded
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
  localparam logic [47:0] KW_FOR    = 48'h0000_0072_6F66;
  localparam logic [47:0] KW_IN     = 48'h0000_0000_6E69;
  localparam logic [47:0] KW_ENDIF  = 48'h0066_6964_6E65;
  localparam logic [47:0] KW_ENDFOR = 48'h726F_6664_6E65;
  localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

  // Bytes beyond the count are always zero, so a full compare suffices
  function automatic kind_t word_kind(input logic [47:0] chars, input logic [2:0] cnt);
    kind_t k;
    k = KIND_IDENT;
    if      (cnt == 3'd2 && chars == KW_IF)     k = KIND_IF;
    else if (cnt == 3'd3 && chars == KW_FOR)    k = KIND_FOR;
    else if (cnt == 3'd2 && chars == KW_IN)     k = KIND_IN;
    else if (cnt == 3'd5 && chars == KW_ENDIF)  k = KIND_ENDIF;
    else if (cnt == 3'd6 && chars == KW_ENDFOR) k = KIND_ENDFOR;
    else if (cnt == 3'd4 && chars == KW_ELSE)   k = KIND_ELSE;
    return k;
  endfunction

  function automatic tok_item_t mk_event(input kind_t kind, input logic [7:0] c,
                                         input logic valid, input logic done);
    tok_item_t e;
    e.token_kind = kind;
    e.char_out   = valid ? c : 8'd0;
    e.char_valid = valid;
    e.token_done = done;
    e.last       = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/template_tag_tokenizer.sv =====
// ---------------------------------------------------------------------------
// template_tag_tokenizer: streaming lexer for a small template language
// Takes one template byte per item and emits up to four token events for it.
// ---------------------------------------------------------------------------
//
//  channel | signals                       | payload
//  --------+-------------------------------+------------------------------
//  chr     | chr_valid, chr_stall, chr     | template byte or end marker
//  tok     | tok_valid, tok_stall, tok     | one token event
//
// An accepted byte is decoded in the same cycle; its events (0 to 4) land in
// a four-entry result buffer that drains on tok, one event per cycle while
// tok_stall is low; this result port sets the sustained rate.
// The next byte is taken while the last buffered event is being taken.
// rst (synchronous) returns the lexer to plain text and empties the buffer.
module template_tag_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  chr_valid,
  output logic                  chr_stall,
  input  ttok_pkg::chr_item_t   chr,
  output logic                  tok_valid,
  input  logic                  tok_stall,
  output ttok_pkg::tok_item_t   tok
);

  // Lexer state
  logic [1:0]  tag_mode,   tag_mode_next;
  logic        quote_open, quote_open_next;
  logic [1:0]  held_delim, held_delim_next;
  logic        run_open,   run_open_next;
  logic [47:0] word_chars, word_chars_next;
  logic [2:0]  word_count, word_count_next;

  // Result buffer
  ttok_pkg::tok_item_t res_buf [4];
  logic [1:0]          rd_ptr;
  logic [2:0]          res_cnt;

  // Decoded events for the current byte
  ttok_pkg::tok_item_t ev [4];
  logic [2:0]          ev_cnt;
  logic                do_text, do_var, do_stmt;
  logic [7:0]          c;

  logic chr_take, tok_take;

  assign tok_valid = (res_cnt != 3'd0);
  assign tok       = res_buf[rd_ptr];
  assign tok_take  = tok_valid && !tok_stall;
  assign chr_stall = !((res_cnt == 3'd0) || (res_cnt == 3'd1 && !tok_stall));
  assign chr_take  = chr_valid && !chr_stall;
  assign c         = chr.ch;

  // Decode one byte into events and next state
  always_comb begin
    tag_mode_next   = tag_mode;
    quote_open_next = quote_open;
    held_delim_next = held_delim;
    run_open_next   = run_open;
    word_chars_next = word_chars;
    word_count_next = word_count;
    ev_cnt  = 3'd0;
    do_text = 1'b0;
    do_var  = 1'b0;
    do_stmt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ev[i] = '0;
    end

    if (chr.end_mark) begin
      // flush the open token, then end of stream
      if (tag_mode == ttok_pkg::MODE_VAR) begin
        if (run_open) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_IDENT, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
        if (held_delim != ttok_pkg::HELD_NONE) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
      end else if (tag_mode == ttok_pkg::MODE_STMT) begin
        if (quote_open) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end else begin
          if (run_open) begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(
              ttok_pkg::word_kind(word_chars, word_count), 8'd0, 1'b0, 1'b1);
            ev_cnt = ev_cnt + 3'd1;
          end
          if (held_delim != ttok_pkg::HELD_NONE) begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
            ev_cnt = ev_cnt + 3'd1;
          end
        end
      end else begin
        if (held_delim != ttok_pkg::HELD_NONE) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_TEXT, ttok_pkg::CH_LBRACE,
                                               1'b1, 1'b0);
          ev_cnt = ev_cnt + 3'd1;
        end
        if (held_delim != ttok_pkg::HELD_NONE || run_open) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
      end
      ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1);
      ev_cnt = ev_cnt + 3'd1;
      tag_mode_next   = ttok_pkg::MODE_TEXT;
      quote_open_next = 1'b0;
      held_delim_next = ttok_pkg::HELD_NONE;
      run_open_next   = 1'b0;
      word_chars_next = '0;
      word_count_next = '0;
    end else if (tag_mode == ttok_pkg::MODE_VAR) begin
      // resolve a held brace in a variable tag
      if (held_delim != ttok_pkg::HELD_NONE) begin
        held_delim_next = ttok_pkg::HELD_NONE;
        if (c == ttok_pkg::CH_RBRACE) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_VARCLOSE, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          tag_mode_next = ttok_pkg::MODE_TEXT;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          do_var = 1'b1;
        end
      end else begin
        do_var = 1'b1;
      end
    end else if (tag_mode == ttok_pkg::MODE_STMT) begin
      // resolve a held percent sign in a statement tag
      if (held_delim != ttok_pkg::HELD_NONE && !quote_open) begin
        held_delim_next = ttok_pkg::HELD_NONE;
        if (c == ttok_pkg::CH_RBRACE) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_STMTCLOSE, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          tag_mode_next = ttok_pkg::MODE_TEXT;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          do_stmt = 1'b1;
        end
      end else begin
        held_delim_next = ttok_pkg::HELD_NONE;
        do_stmt = 1'b1;
      end
    end else begin
      // resolve a held brace in text
      if (held_delim != ttok_pkg::HELD_NONE) begin
        held_delim_next = ttok_pkg::HELD_NONE;
        if (c == ttok_pkg::CH_LBRACE || c == ttok_pkg::CH_PCT) begin
          if (run_open) begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b1);
            ev_cnt = ev_cnt + 3'd1;
          end
          run_open_next = 1'b0;
          if (c == ttok_pkg::CH_LBRACE) begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_VAROPEN, 8'd0, 1'b0, 1'b1);
            tag_mode_next = ttok_pkg::MODE_VAR;
          end else begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_STMTOPEN, 8'd0, 1'b0, 1'b1);
            tag_mode_next = ttok_pkg::MODE_STMT;
          end
          ev_cnt = ev_cnt + 3'd1;
          quote_open_next = 1'b0;
          word_chars_next = '0;
          word_count_next = '0;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_TEXT, ttok_pkg::CH_LBRACE,
                                               1'b1, 1'b0);
          ev_cnt = ev_cnt + 3'd1;
          run_open_next = 1'b1;
          do_text = 1'b1;
        end
      end else begin
        do_text = 1'b1;
      end
    end

    // plain text byte
    if (do_text) begin
      if (c == ttok_pkg::CH_LBRACE) begin
        held_delim_next = ttok_pkg::HELD_LBRACE;
      end else begin
        ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_TEXT, c, 1'b1, 1'b0);
        ev_cnt = ev_cnt + 3'd1;
        run_open_next = 1'b1;
      end
    end

    // variable tag byte
    if (do_var) begin
      if (ttok_pkg::is_word_byte(c)) begin
        ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_IDENT, c, 1'b1, 1'b0);
        ev_cnt = ev_cnt + 3'd1;
        run_open_next = 1'b1;
      end else begin
        if (run_open_next) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_IDENT, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          run_open_next = 1'b0;
        end
        if (c == ttok_pkg::CH_SPACE) begin
          // drop spaces
        end else if (c == ttok_pkg::CH_RBRACE) begin
          held_delim_next = ttok_pkg::HELD_RBRACE;
        end else if (c == ttok_pkg::CH_DOT) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_DOT, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
      end
    end

    // statement tag byte
    if (do_stmt) begin
      if (quote_open) begin
        if (c == ttok_pkg::CH_QUOTE) begin
          if (run_open) begin
            ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_STRLIT, 8'd0, 1'b0, 1'b1);
            ev_cnt = ev_cnt + 3'd1;
          end
          run_open_next = 1'b0;
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_QCLOSE, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          quote_open_next = 1'b0;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_STRLIT, c, 1'b1, 1'b0);
          ev_cnt = ev_cnt + 3'd1;
          run_open_next = 1'b1;
        end
      end else if (ttok_pkg::is_word_byte(c)) begin
        ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_IDENT, c, 1'b1, 1'b0);
        ev_cnt = ev_cnt + 3'd1;
        run_open_next = 1'b1;
        // collect the first six bytes of the word
        if (word_count < 3'(ttok_pkg::WORD_MAX)) begin
          for (int i = 0; i < ttok_pkg::WORD_MAX; i++) begin
            if (word_count == 3'(i)) begin
              word_chars_next[8*i +: 8] = c;
            end
          end
          word_count_next = word_count + 3'd1;
        end else begin
          word_count_next = ttok_pkg::WCNT_LONG;
        end
      end else begin
        // close the word, then classify the byte
        if (run_open) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(
            ttok_pkg::word_kind(word_chars, word_count), 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
        run_open_next   = 1'b0;
        word_chars_next = '0;
        word_count_next = '0;
        if (c == ttok_pkg::CH_SPACE) begin
          // drop spaces
        end else if (c == ttok_pkg::CH_PCT) begin
          held_delim_next = ttok_pkg::HELD_PCT;
        end else if (c == ttok_pkg::CH_QUOTE) begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_QOPEN, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
          quote_open_next = 1'b1;
        end else begin
          ev[ev_cnt[1:0]] = ttok_pkg::mk_event(ttok_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
          ev_cnt = ev_cnt + 3'd1;
        end
      end
    end

    // mark the final event of this byte
    if (ev_cnt != 3'd0) begin
      ev[2'(ev_cnt - 3'd1)].last = 1'b1;
    end
  end

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mode   <= ttok_pkg::MODE_TEXT;
      quote_open <= 1'b0;
      held_delim <= ttok_pkg::HELD_NONE;
      run_open   <= 1'b0;
      word_chars <= '0;
      word_count <= '0;
    end else if (chr_take) begin
      tag_mode   <= tag_mode_next;
      quote_open <= quote_open_next;
      held_delim <= held_delim_next;
      run_open   <= run_open_next;
      word_chars <= word_chars_next;
      word_count <= word_count_next;
    end
  end

  // Load the result buffer, or drain one event
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      res_cnt <= '0;
    end else if (chr_take) begin
      rd_ptr  <= '0;
      res_cnt <= ev_cnt;
    end else if (tok_take) begin
      rd_ptr  <= rd_ptr + 2'd1;
      res_cnt <= res_cnt - 3'd1;
    end
  end

  // Event payloads need no reset
  always_ff @(posedge clk) begin
    if (chr_take) begin
      for (int i = 0; i < 4; i++) begin
        res_buf[i] <= ev[i];
      end
    end
  end

endmodule

// ===== verif/template_tag_tokenizer_tb.sv =====
// ---------------------------------------------------------------------------
// template_tag_tokenizer_tb: self-checking bench for the template tokenizer
// Walks a short table of hand-picked bytes, then streams random templates
// built from text, variable tags, statement tags, quoted literals and noise.
// A behavioral lexer predicts the events of rows without typed ones; both channels idle at random.
// ---------------------------------------------------------------------------
module template_tag_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttok_pkg::*;

  typedef struct {
    chr_item_t item;
    int        n_typed;   // -1: expectations come from the lexer model
    tok_item_t exp_ev[4];
  } stim_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      chr_valid = 1'b0;
  logic      chr_stall;
  chr_item_t chr = '0;
  logic      tok_valid;
  logic      tok_stall = 1'b0;
  tok_item_t tok;

  // Lexer model state
  logic [1:0]  lx_mode;
  logic        lx_quote;
  logic [1:0]  lx_held;
  logic        lx_run;
  logic [47:0] lx_word;
  logic [2:0]  lx_wcnt;
  tok_item_t   lex_events[$];

  tok_item_t   pending_tokens[$];
  stim_row_t   dir_rows[$];
  chr_item_t   template_bytes[$];
  string       keywords[6] = '{"if", "for", "in", "endif", "endfor", "else"};

  logic quiet = 1'b0;
  int   stall_left = 0;
  int   mismatches = 0;
  int   items_sent = 0;
  int   templates = 0;
  int   events_seen = 0;
  int   kw_seen = 0;

  template_tag_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Lexer model
  // ---------------------------------------------------------------------
  function automatic tok_item_t token_event(input kind_t k, input logic [7:0] c,
                                            input logic is_char, input logic fin);
    tok_item_t e;
    e.token_kind = k;
    e.char_out   = is_char ? c : 8'h00;
    e.char_valid = is_char;
    e.token_done = !is_char;
    e.last       = fin;
    return e;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
  endfunction

  // Lay a string out first byte lowest, as the word buffer holds it
  function automatic logic [47:0] pack_le(input string s);
    logic [47:0] w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic kind_t keyword_kind();
    kind_t k;
    k = KIND_IDENT;
    foreach (keywords[i])
      if (lx_wcnt == keywords[i].len() && lx_word == pack_le(keywords[i]))
        k = kind_t'(KIND_IF + i);
    return k;
  endfunction

  task automatic lex_clear();
    lx_mode  = MODE_TEXT;
    lx_quote = 1'b0;
    lx_held  = HELD_NONE;
    lx_run   = 1'b0;
    lx_word  = '0;
    lx_wcnt  = '0;
  endtask

  // Drop anything past four events per byte
  task automatic lex_put(input tok_item_t e);
    if (lex_events.size() < 4) lex_events.push_back(e);
  endtask

  task automatic close_word();
    if (lx_run) lex_put(token_event(keyword_kind(), 8'h00, 1'b0, 1'b0));
    lx_run  = 1'b0;
    lx_word = '0;
    lx_wcnt = '0;
  endtask

  task automatic text_char(input logic [7:0] c);
    if (c == CH_LBRACE) begin
      lx_held = HELD_LBRACE;
    end else begin
      lex_put(token_event(KIND_TEXT, c, 1'b1, 1'b0));
      lx_run = 1'b1;
    end
  endtask

  task automatic var_char(input logic [7:0] c);
    if (is_ident_char(c)) begin
      lex_put(token_event(KIND_IDENT, c, 1'b1, 1'b0));
      lx_run = 1'b1;
    end else begin
      if (lx_run) begin
        lex_put(token_event(KIND_IDENT, 8'h00, 1'b0, 1'b0));
        lx_run = 1'b0;
      end
      if (c == CH_RBRACE) lx_held = HELD_RBRACE;
      else if (c == CH_DOT) lex_put(token_event(KIND_DOT, 8'h00, 1'b0, 1'b0));
      else if (c != CH_SPACE) lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
    end
  endtask

  task automatic stmt_char(input logic [7:0] c);
    if (lx_quote) begin
      if (c == CH_QUOTE) begin
        if (lx_run) lex_put(token_event(KIND_STRLIT, 8'h00, 1'b0, 1'b0));
        lx_run = 1'b0;
        lex_put(token_event(KIND_QCLOSE, 8'h00, 1'b0, 1'b0));
        lx_quote = 1'b0;
      end else begin
        lex_put(token_event(KIND_STRLIT, c, 1'b1, 1'b0));
        lx_run = 1'b1;
      end
    end else if (is_ident_char(c)) begin
      lex_put(token_event(KIND_IDENT, c, 1'b1, 1'b0));
      lx_run = 1'b1;
      if (lx_wcnt < WORD_MAX) begin
        lx_word[8*lx_wcnt +: 8] = c;
        lx_wcnt = lx_wcnt + 3'd1;
      end else begin
        lx_wcnt = WCNT_LONG;
      end
    end else begin
      close_word();
      if (c == CH_PCT) begin
        lx_held = HELD_PCT;
      end else if (c == CH_QUOTE) begin
        lex_put(token_event(KIND_QOPEN, 8'h00, 1'b0, 1'b0));
        lx_quote = 1'b1;
      end else if (c != CH_SPACE) begin
        lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
      end
    end
  endtask

  // Compute the events of one accepted item into lex_events
  task automatic lex_step(input chr_item_t it);
    logic [7:0] c;
    tok_item_t  tail;
    c = it.ch;
    lex_events.delete();
    if (it.end_mark) begin
      if (lx_mode == MODE_VAR) begin
        if (lx_run) lex_put(token_event(KIND_IDENT, 8'h00, 1'b0, 1'b0));
        if (lx_held != HELD_NONE) lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
      end else if (lx_mode == MODE_STMT) begin
        if (lx_quote) begin
          lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
        end else begin
          close_word();
          if (lx_held != HELD_NONE) lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
        end
      end else begin
        if (lx_held != HELD_NONE) begin
          lex_put(token_event(KIND_TEXT, CH_LBRACE, 1'b1, 1'b0));
          lx_run = 1'b1;
        end
        if (lx_run) lex_put(token_event(KIND_TEXT, 8'h00, 1'b0, 1'b0));
      end
      lex_put(token_event(KIND_EOF, 8'h00, 1'b0, 1'b0));
      lex_clear();
    end else if (lx_mode == MODE_VAR) begin
      if (lx_held != HELD_NONE) begin
        lx_held = HELD_NONE;
        if (c == CH_RBRACE) begin
          lex_put(token_event(KIND_VARCLOSE, 8'h00, 1'b0, 1'b0));
          lx_mode = MODE_TEXT;
        end else begin
          lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
          var_char(c);
        end
      end else begin
        var_char(c);
      end
    end else if (lx_mode == MODE_STMT) begin
      if (lx_held != HELD_NONE && !lx_quote) begin
        lx_held = HELD_NONE;
        if (c == CH_RBRACE) begin
          lex_put(token_event(KIND_STMTCLOSE, 8'h00, 1'b0, 1'b0));
          lx_mode = MODE_TEXT;
        end else begin
          lex_put(token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0));
          stmt_char(c);
        end
      end else begin
        lx_held = HELD_NONE;
        stmt_char(c);
      end
    end else begin
      if (lx_held != HELD_NONE) begin
        lx_held = HELD_NONE;
        if (c == CH_LBRACE || c == CH_PCT) begin
          if (lx_run) lex_put(token_event(KIND_TEXT, 8'h00, 1'b0, 1'b0));
          lx_run = 1'b0;
          if (c == CH_LBRACE) lex_put(token_event(KIND_VAROPEN, 8'h00, 1'b0, 1'b0));
          else lex_put(token_event(KIND_STMTOPEN, 8'h00, 1'b0, 1'b0));
          lx_mode  = (c == CH_LBRACE) ? MODE_VAR : MODE_STMT;
          lx_quote = 1'b0;
          lx_word  = '0;
          lx_wcnt  = '0;
        end else begin
          lex_put(token_event(KIND_TEXT, CH_LBRACE, 1'b1, 1'b0));
          lx_run = 1'b1;
          text_char(c);
        end
      end else begin
        text_char(c);
      end
    end
    // Flag the final event of this item
    if (lex_events.size() > 0) begin
      tail = lex_events[lex_events.size() - 1];
      tail.last = 1'b1;
      lex_events[lex_events.size() - 1] = tail;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(input logic [7:0] c, input logic em, input int n = -1,
                         input tok_item_t e0 = '0, input tok_item_t e1 = '0,
                         input tok_item_t e2 = '0);
    stim_row_t r;
    r.item.ch       = c;
    r.item.end_mark = em;
    r.n_typed       = n;
    r.exp_ev[0]     = e0;
    r.exp_ev[1]     = e1;
    r.exp_ev[2]     = e2;
    r.exp_ev[3]     = '0;
    dir_rows.push_back(r);
  endtask

  // Queue one template byte, now and then swapped for a random one
  task automatic push_ch(input logic [7:0] c);
    chr_item_t it;
    it.ch       = ($urandom_range(0, 99) < 3) ? 8'($urandom) : c;
    it.end_mark = 1'b0;
    template_bytes.push_back(it);
  endtask

  task automatic push_end();
    chr_item_t it;
    it.ch       = 8'($urandom);
    it.end_mark = 1'b1;
    template_bytes.push_back(it);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 36) return 8'h61 + 8'(r - 10);
    if (r < 62) return 8'h41 + 8'(r - 36);
    return CH_UNDER;
  endfunction

  // Keyword, keyword with a tail, or a random name (sometimes past six bytes)
  task automatic add_word();
    int    r;
    int    n;
    string kw;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      kw = keywords[$urandom_range(0, 5)];
      for (int i = 0; i < kw.len(); i++) push_ch(kw[i]);
      if (r == 5) push_ch(ident_char());
    end else begin
      n = (r == 9) ? $urandom_range(6, 9) : $urandom_range(1, 5);
      repeat (n) push_ch(ident_char());
    end
  endtask

  task automatic add_text();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 99) < 10) begin
        push_ch(CH_LBRACE);
        push_ch(ident_char());
      end else begin
        push_ch(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
  endtask

  task automatic add_var_tag();
    int n;
    n = $urandom_range(1, 3);
    push_ch(CH_LBRACE);
    push_ch(CH_LBRACE);
    if ($urandom_range(0, 1)) push_ch(CH_SPACE);
    for (int i = 0; i < n; i++) begin
      if (i > 0) push_ch(CH_DOT);
      add_word();
    end
    if ($urandom_range(0, 1)) push_ch(CH_SPACE);
    push_ch(CH_RBRACE);
    push_ch(CH_RBRACE);
  endtask

  task automatic add_quoted();
    int n;
    n = $urandom_range(0, 5);
    push_ch(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       push_ch(CH_SPACE);
        1:       push_ch(CH_PCT);
        2:       push_ch(CH_RBRACE);
        3:       push_ch(ident_char());
        default: push_ch(8'($urandom_range(8'h23, 8'h7E)));
      endcase
    end
    push_ch(CH_QUOTE);
  endtask

  task automatic add_stmt_tag();
    int n;
    n = $urandom_range(1, 4);
    push_ch(CH_LBRACE);
    push_ch(CH_PCT);
    push_ch(CH_SPACE);
    for (int i = 0; i < n; i++) begin
      if (i > 0) push_ch(CH_SPACE);
      if ($urandom_range(0, 3) == 0) add_quoted();
      else add_word();
    end
    if ($urandom_range(0, 1)) push_ch(CH_SPACE);
    push_ch(CH_PCT);
    push_ch(CH_RBRACE);
  endtask

  // Open a tag and feed it raw bytes, sometimes ending the template inside it
  task automatic add_broken();
    int n;
    n = $urandom_range(0, 4);
    push_ch(CH_LBRACE);
    push_ch($urandom_range(0, 1) ? CH_LBRACE : CH_PCT);
    repeat (n) push_ch(8'($urandom));
    if ($urandom_range(0, 2) == 0) push_end();
  endtask

  task automatic add_template();
    int nseg;
    nseg = $urandom_range(1, 5);
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_text();
        3, 4:    add_var_tag();
        5, 6, 7: add_stmt_tag();
        default: add_broken();
      endcase
    end
    push_end();
    templates++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: present one item, wait for it to be taken, record its events
  // ---------------------------------------------------------------------
  task automatic send_row(input stim_row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      chr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chr_valid <= 1'b1;
    chr       <= r.item;
    do @(posedge clk); while (chr_stall);
    lex_step(r.item);
    if (r.n_typed < 0) begin
      foreach (lex_events[i]) pending_tokens.push_back(lex_events[i]);
    end else begin
      for (int i = 0; i < r.n_typed; i++) pending_tokens.push_back(r.exp_ev[i]);
    end
    items_sent++;
    if ($urandom_range(0, 39) == 0) quiet <= ~quiet;
  endtask

  // Hold off the sender until every expected event has come back
  task automatic drain();
    chr_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    stim_row_t r;
    lex_clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every mode and delimiter and three end-of-input cases
    add_row("a", 1'b0, 1, token_event(KIND_TEXT, "a", 1'b1, 1'b1));
    add_row(CH_LBRACE, 1'b0, 0);
    // lone brace turns into text
    add_row("b", 1'b0, 2, token_event(KIND_TEXT, CH_LBRACE, 1'b1, 1'b0),
            token_event(KIND_TEXT, "b", 1'b1, 1'b1));
    add_row(CH_LBRACE, 1'b0, 0);
    add_row(CH_LBRACE, 1'b0, 2, token_event(KIND_TEXT, 8'h00, 1'b0, 1'b0),
            token_event(KIND_VAROPEN, 8'h00, 1'b0, 1'b1));
    add_row("x", 1'b0);
    add_row(CH_DOT, 1'b0);
    add_row(8'hFF, 1'b0, 1, token_event(KIND_ERROR, 8'h00, 1'b0, 1'b1));
    add_row(CH_RBRACE, 1'b0);
    // held brace not followed by a brace
    add_row("q", 1'b0, 2, token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0),
            token_event(KIND_IDENT, "q", 1'b1, 1'b1));
    add_row(CH_SPACE, 1'b0);
    add_row(CH_RBRACE, 1'b0, 0);
    add_row(CH_RBRACE, 1'b0, 1, token_event(KIND_VARCLOSE, 8'h00, 1'b0, 1'b1));
    add_row(CH_LBRACE, 1'b0, 0);
    add_row(CH_PCT, 1'b0, 1, token_event(KIND_STMTOPEN, 8'h00, 1'b0, 1'b1));
    add_row("i", 1'b0);
    add_row("f", 1'b0);
    add_row(CH_SPACE, 1'b0);
    add_row(CH_QUOTE, 1'b0, 1, token_event(KIND_QOPEN, 8'h00, 1'b0, 1'b1));
    add_row(CH_PCT, 1'b0);
    add_row(CH_RBRACE, 1'b0);
    add_row(CH_QUOTE, 1'b0);
    // empty literal
    add_row(CH_QUOTE, 1'b0);
    add_row(CH_QUOTE, 1'b0, 1, token_event(KIND_QCLOSE, 8'h00, 1'b0, 1'b1));
    add_row(CH_PCT, 1'b0, 0);
    add_row(8'hFF, 1'b1, 2, token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0),
            token_event(KIND_EOF, 8'h00, 1'b0, 1'b1));
    // held brace at end of input
    add_row(CH_LBRACE, 1'b0, 0);
    add_row(8'h00, 1'b1, 3, token_event(KIND_TEXT, CH_LBRACE, 1'b1, 1'b0),
            token_event(KIND_TEXT, 8'h00, 1'b0, 1'b0),
            token_event(KIND_EOF, 8'h00, 1'b0, 1'b1));
    // unterminated quote at end of input
    add_row(CH_LBRACE, 1'b0);
    add_row(CH_PCT, 1'b0);
    add_row(CH_QUOTE, 1'b0);
    add_row(8'h55, 1'b1, 2, token_event(KIND_ERROR, 8'h00, 1'b0, 1'b0),
            token_event(KIND_EOF, 8'h00, 1'b0, 1'b1));

    foreach (dir_rows[i]) send_row(dir_rows[i]);
    drain();

    // Random templates
    while (dir_rows.size() + template_bytes.size() < 360) add_template();
    r.n_typed = -1;
    foreach (template_bytes[i]) begin
      r.item = template_bytes[i];
      send_row(r);
      if (r.item.end_mark && $urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d items in %0d random templates plus a directed walk,",
             items_sent, templates);
    $display("  checked %0d token events, %0d of them keyword closes", events_seen, kw_seen);
    if (mismatches == 0) begin
      $display("template_tag_tokenizer_tb: clean");
    end else begin
      $display("template_tag_tokenizer_tb: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: check each taken event, then decide the next stall
  // ---------------------------------------------------------------------
  task automatic field_diff(input string name, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : token_rx
    tok_item_t want;
    if (!rst && tok_valid && !tok_stall) begin
      events_seen++;
      if (tok.token_done && tok.token_kind >= KIND_IF && tok.token_kind <= KIND_ELSE)
        kw_seen++;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token event, expected none got %p", $time, tok);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        field_diff("token_kind", 8'(want.token_kind), 8'(tok.token_kind));
        field_diff("char_out", want.char_out, tok.char_out);
        field_diff("char_valid", 8'(want.char_valid), 8'(tok.char_valid));
        field_diff("token_done", 8'(want.token_done), 8'(tok.token_done));
        field_diff("last", 8'(want.last), 8'(tok.last));
      end
    end
    // Start a new stall stretch now and then
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left--;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("template_tag_tokenizer_tb: errors");
    $finish;
  end

endmodule
